[rtl/msc_pkg.sv]
// msc_pkg: shared types and constants for the MIPS subset core.
// No dependencies; imported by every module of the core.
`timescale 1ns / 1ps
package msc_pkg;
    localparam int MEM_WORDS = 1024;
    localparam int AW        = $clog2(MEM_WORDS);
    localparam int PC_W      = 10;
    localparam int PW_W      = 11;

    // primary opcodes
    localparam logic [5:0] OP_RTYPE = 6'h00;
    localparam logic [5:0] OP_J     = 6'h02;
    localparam logic [5:0] OP_JAL   = 6'h03;
    localparam logic [5:0] OP_BEQ   = 6'h04;
    localparam logic [5:0] OP_BNE   = 6'h05;
    localparam logic [5:0] OP_BLEZ  = 6'h06;
    localparam logic [5:0] OP_BGTZ  = 6'h07;
    localparam logic [5:0] OP_ADDI  = 6'h08;
    localparam logic [5:0] OP_ADDIU = 6'h09;
    localparam logic [5:0] OP_SLTI  = 6'h0A;
    localparam logic [5:0] OP_SLTIU = 6'h0B;
    localparam logic [5:0] OP_ANDI  = 6'h0C;
    localparam logic [5:0] OP_ORI   = 6'h0D;
    localparam logic [5:0] OP_XORI  = 6'h0E;
    localparam logic [5:0] OP_LB    = 6'h20;
    localparam logic [5:0] OP_LW    = 6'h24;
    localparam logic [5:0] OP_SW    = 6'h28;
    localparam logic [5:0] OP_SH    = 6'h29;
    localparam logic [5:0] OP_SB    = 6'h2A;

    // R-type functs
    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRL  = 6'h02;
    localparam logic [5:0] FN_SRA  = 6'h03;
    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_JALR = 6'h09;
    localparam logic [5:0] FN_MFHI = 6'h10;
    localparam logic [5:0] FN_MFLO = 6'h12;
    localparam logic [5:0] FN_MULT = 6'h18;
    localparam logic [5:0] FN_MULTU= 6'h19;
    localparam logic [5:0] FN_DIV  = 6'h1A;
    localparam logic [5:0] FN_DIVU = 6'h1B;
    localparam logic [5:0] FN_ADD  = 6'h20;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUB  = 6'h22;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_AND  = 6'h24;
    localparam logic [5:0] FN_OR   = 6'h25;
    localparam logic [5:0] FN_XOR  = 6'h26;
    localparam logic [5:0] FN_NOR  = 6'h27;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load_wr;    // write load word into memory
        logic fetch;      // read memory at pc
        logic decode;     // latch instruction, read registers
        logic execute;    // address calc for loads and stores
        logic mem_rd;     // data memory read
        logic commit;     // write back, build result
        logic md_start;   // start multiply/divide
        logic halt;       // build halted result
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_md;      // decoded op uses the multiply/divide unit
        logic is_load;    // decoded op reads data memory
        logic md_done;
    } status_t;

    typedef struct packed {
        logic [PC_W-1:0] next_pc;
        logic            reg_written;
        logic [4:0]      reg_index;
        logic [31:0]     reg_value;
        logic            mem_written;
        logic [PC_W-1:0] mem_index;
        logic [31:0]     mem_value;
        logic            unknown_op;
        logic            halted;
    } result_t;
endpackage

[rtl/msc_muldiv.sv]
// msc_muldiv: multi-cycle multiply (16 bits per cycle) and radix-2 divide.
// Depends on msc_pkg.
`timescale 1ns / 1ps
module msc_muldiv (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [5:0]  funct,
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  logic [31:0] hi_in,
    input  logic [31:0] lo_in,
    output logic        done,
    output logic [31:0] hi_out,
    output logic [31:0] lo_out
);
    import msc_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_MUL0, S_MUL1, S_DIV, S_FIX} state_t;
    state_t state_reg, state_next;

    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] ma_reg, ma_next, mb_reg, mb_next;
    logic        neg_q_reg, neg_q_next, neg_r_reg, neg_r_next;
    logic [63:0] acc_reg, acc_next;     // product, or {rem, quotient}
    logic        done_reg, done_next;
    logic [31:0] hi_reg, hi_next, lo_reg, lo_next;

    logic        sgn;
    logic        na, nb;
    logic [47:0] part;
    logic [32:0] trial;
    logic [63:0] shifted;

    assign sgn = (funct == FN_MULT) || (funct == FN_DIV);
    assign na  = sgn & a[31];
    assign nb  = sgn & b[31];

    // 32x16 partial product
    always_comb
    begin
        if (state_reg == S_MUL0)
            part = {16'd0, ma_reg} * {32'd0, mb_reg[15:0]};
        else
            part = {16'd0, ma_reg} * {32'd0, mb_reg[31:16]};
    end

    // remainder can reach 33 bits before the subtract
    assign shifted = {acc_reg[62:0], 1'b0};
    assign trial   = {acc_reg[63], shifted[63:32]} - {1'b0, mb_reg};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        neg_q_next = neg_q_reg;
        neg_r_next = neg_r_reg;
        acc_next   = acc_reg;
        done_next  = 1'b0;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ma_next    = na ? (32'd0 - a) : a;
                    mb_next    = nb ? (32'd0 - b) : b;
                    neg_q_next = na ^ nb;
                    neg_r_next = na;
                    cnt_next   = 6'd0;
                    if ((funct == FN_MULT) || (funct == FN_MULTU))
                    begin
                        acc_next   = 64'd0;
                        state_next = S_MUL0;
                    end
                    else if (b == 32'd0)
                    begin
                        hi_next    = hi_in;
                        lo_next    = lo_in;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        acc_next   = {32'd0, na ? (32'd0 - a) : a};
                        state_next = S_DIV;
                    end
                end
            end
            S_MUL0:
            begin
                acc_next   = {16'd0, part};
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                acc_next   = acc_reg + {part, 16'd0};
                state_next = S_FIX;
            end
            S_DIV:
            begin
                if (!trial[32])
                    acc_next = {trial[31:0], shifted[31:1], 1'b1};
                else
                    acc_next = shifted;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                    state_next = S_FIX;
            end
            S_FIX:
            begin
                if (cnt_reg == 6'd0)
                begin
                    // product: negate when signs differ
                    if (neg_q_reg)
                        {hi_next, lo_next} = 64'd0 - acc_reg;
                    else
                        {hi_next, lo_next} = acc_reg;
                end
                else
                begin
                    lo_next = neg_q_reg ? (32'd0 - acc_reg[31:0]) : acc_reg[31:0];
                    hi_next = neg_r_reg ? (32'd0 - acc_reg[63:32]) : acc_reg[63:32];
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        ma_reg    <= ma_next;
        mb_reg    <= mb_next;
        neg_q_reg <= neg_q_next;
        neg_r_reg <= neg_r_next;
        acc_reg   <= acc_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
    end

    assign done   = done_reg;
    assign hi_out = hi_reg;
    assign lo_out = lo_reg;
endmodule

[rtl/msc_datapath.sv]
// msc_datapath: memory, register file, pc, hi/lo, ALU and result assembly.
// Depends on msc_pkg and msc_muldiv.
`timescale 1ns / 1ps
module msc_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  msc_pkg::cmd_t          cmd,
    output msc_pkg::status_t       status,
    input  logic [9:0]             load_index,
    input  logic [31:0]            load_data,
    input  logic [msc_pkg::PW_W-1:0] program_words,
    output logic                   pc_done,
    output msc_pkg::result_t       result
);
    import msc_pkg::*;

    logic [31:0] mem [MEM_WORDS];
    logic [31:0] rf  [32];
    logic [31:0] mem_q;
    logic [31:0] rf_a_q, rf_b_q;

    logic [PC_W-1:0] pc_reg;
    logic [31:0] hi_reg, lo_reg;
    logic [31:0] ins_reg;
    logic [AW-1:0] addr_reg;
    result_t res_reg, res_next;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;
    logic          mem_we;
    logic [AW-1:0] mem_raddr;

    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, sh;
    logic [31:0] imm, simm, a, b;
    logic [PC_W-1:0] link;
    logic        md_done;
    logic [31:0] md_hi, md_lo;

    assign op   = ins_reg[31:26];
    assign rs   = ins_reg[25:21];
    assign rt   = ins_reg[20:16];
    assign rd   = ins_reg[15:11];
    assign sh   = ins_reg[10:6];
    assign fn   = ins_reg[5:0];
    assign imm  = {16'd0, ins_reg[15:0]};
    assign simm = {{16{ins_reg[15]}}, ins_reg[15:0]};
    assign a    = (rs == 5'd0) ? 32'd0 : rf_a_q;
    assign b    = (rt == 5'd0) ? 32'd0 : rf_b_q;
    assign link = pc_reg + PC_W'(1);

    assign pc_done = {1'b0, pc_reg} >= program_words;

    // memory port: one write, one registered read
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = load_index[AW-1:0];
        mem_wdata = load_data;
        if (cmd.load_wr)
            mem_we = 1'b1;
        else if (cmd.commit && res_next.mem_written)
        begin
            mem_we    = 1'b1;
            mem_waddr = res_next.mem_index[AW-1:0];
            mem_wdata = res_next.mem_value;
        end
        mem_raddr = cmd.fetch ? pc_reg[AW-1:0] : addr_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        mem_q <= mem[mem_raddr];
    end

    // instruction latch and register reads in decode, fetched word now on mem_q
    always_ff @(posedge clk)
    begin
        if (cmd.decode)
        begin
            ins_reg <= mem_q;
            rf_a_q  <= rf[mem_q[25:21]];
            rf_b_q  <= rf[mem_q[20:16]];
        end
        if (cmd.execute)
            addr_reg <= AW'(a + simm);
    end

    // register file, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 32; i++)
                rf[i] <= '0;
        end
        else if (cmd.commit && res_next.reg_written)
            rf[res_next.reg_index] <= res_next.reg_value;
    end

    msc_muldiv u_md (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.md_start),
        .funct  (fn),
        .a      (a),
        .b      (b),
        .hi_in  (hi_reg),
        .lo_in  (lo_reg),
        .done   (md_done),
        .hi_out (md_hi),
        .lo_out (md_lo)
    );

    assign status.is_md   = (op == OP_RTYPE) && ((fn == FN_MULT) || (fn == FN_MULTU)
                            || (fn == FN_DIV) || (fn == FN_DIVU));
    assign status.is_load = (op == OP_LB) || (op == OP_LW);
    assign status.md_done = md_done;

    // execute and result build
    always_comb
    begin
        logic wr, take;
        logic [4:0] ri;
        logic [31:0] rv;
        logic [PC_W-1:0] npc;
        wr   = 1'b0;
        take = 1'b0;
        ri   = 5'd0;
        rv   = 32'd0;
        npc  = link;
        res_next = '0;
        if (cmd.halt)
        begin
            res_next.next_pc = pc_reg;
            res_next.halted  = 1'b1;
        end
        else if (cmd.load_wr)
        begin
            res_next.next_pc = pc_reg;
        end
        else
        begin
            case (op)
                OP_RTYPE:
                begin
                    case (fn)
                        FN_ADD, FN_ADDU: begin wr = 1'b1; ri = rd; rv = a + b; end
                        FN_SUB, FN_SUBU: begin wr = 1'b1; ri = rd; rv = a - b; end
                        FN_AND:  begin wr = 1'b1; ri = rd; rv = a & b; end
                        FN_OR:   begin wr = 1'b1; ri = rd; rv = a | b; end
                        FN_XOR:  begin wr = 1'b1; ri = rd; rv = a ^ b; end
                        FN_NOR:  begin wr = 1'b1; ri = rd; rv = ~(a | b); end
                        FN_SLL:  begin wr = 1'b1; ri = rd; rv = b << sh; end
                        FN_SRL:  begin wr = 1'b1; ri = rd; rv = b >> sh; end
                        FN_SRA:  begin wr = 1'b1; ri = rd; rv = $signed(b) >>> sh; end
                        FN_MFHI: begin wr = 1'b1; ri = rd; rv = hi_reg; end
                        FN_MFLO: begin wr = 1'b1; ri = rd; rv = lo_reg; end
                        FN_MULT, FN_MULTU, FN_DIV, FN_DIVU: ;
                        FN_JR:   npc = a[PC_W-1:0];
                        FN_JALR:
                        begin
                            npc = a[PC_W-1:0];
                            wr = 1'b1; ri = 5'd31; rv = {22'd0, link};
                        end
                        default: res_next.unknown_op = 1'b1;
                    endcase
                end
                OP_J:  npc = ins_reg[PC_W-1:0];
                OP_JAL:
                begin
                    npc = ins_reg[PC_W-1:0];
                    wr = 1'b1; ri = 5'd31; rv = {22'd0, link};
                end
                OP_ADDI, OP_ADDIU: begin wr = 1'b1; ri = rt; rv = a + simm; end
                OP_ANDI: begin wr = 1'b1; ri = rt; rv = a & imm; end
                OP_ORI:  begin wr = 1'b1; ri = rt; rv = a | imm; end
                OP_XORI: begin wr = 1'b1; ri = rt; rv = a ^ imm; end
                OP_SLTI: begin wr = 1'b1; ri = rt; rv = {31'd0, $signed(a) < $signed(simm)}; end
                OP_SLTIU: begin wr = 1'b1; ri = rt; rv = {31'd0, a < simm}; end
                OP_BEQ:  take = (a == b);
                OP_BNE:  take = (a != b);
                OP_BLEZ: take = (a == 32'd0) || a[31];
                OP_BGTZ: take = (a != 32'd0) && !a[31];
                OP_LB:   begin wr = 1'b1; ri = rt; rv = {{24{mem_q[7]}}, mem_q[7:0]}; end
                OP_LW:   begin wr = 1'b1; ri = rt; rv = mem_q; end
                OP_SW:
                begin
                    res_next.mem_written = 1'b1;
                    res_next.mem_value = b;
                end
                OP_SH:
                begin
                    res_next.mem_written = 1'b1;
                    res_next.mem_value = {16'd0, b[15:0]};
                end
                OP_SB:
                begin
                    res_next.mem_written = 1'b1;
                    res_next.mem_value = {24'd0, b[7:0]};
                end
                default: res_next.unknown_op = 1'b1;
            endcase
            if (take)
                npc = link + ins_reg[PC_W-1:0];
            if (res_next.mem_written)
                res_next.mem_index = PC_W'(addr_reg);
            if (wr && (ri != 5'd0))
            begin
                res_next.reg_written = 1'b1;
                res_next.reg_index   = ri;
                res_next.reg_value   = rv;
            end
            res_next.next_pc = npc;
        end
    end

    // pc, hi/lo and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= '0;
            hi_reg <= '0;
            lo_reg <= '0;
        end
        else
        begin
            if (cmd.commit)
                pc_reg <= res_next.next_pc;
            if (md_done)
            begin
                hi_reg <= md_hi;
                lo_reg <= md_lo;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit || cmd.halt || cmd.load_wr)
            res_reg <= res_next;
    end

    assign result = res_reg;
endmodule

[rtl/msc_ctrl.sv]
// msc_ctrl: sequencer for load, fetch, decode, execute, memory and commit.
// Depends on msc_pkg.
`timescale 1ns / 1ps
module msc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_cmd,
    output logic             in_ready,
    input  logic             pc_done,
    input  msc_pkg::status_t status,
    output msc_pkg::cmd_t    cmd,
    output logic             out_valid,
    input  logic             out_ready
);
    import msc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_FETCH, S_DECODE, S_EXEC, S_MEM, S_MD, S_COMMIT, S_MDWAIT
    } state_t;
    state_t state_reg, state_next;
    logic   ov_reg, ov_next;
    logic   accept;

    assign in_ready = (state_reg == S_IDLE) && !ov_reg;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        ov_next    = ov_reg && !out_ready;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_cmd == CMD_LOAD)
                    begin
                        cmd.load_wr = 1'b1;
                        ov_next = 1'b1;
                    end
                    else if (pc_done)
                    begin
                        cmd.halt = 1'b1;
                        ov_next = 1'b1;
                    end
                    else
                        state_next = S_FETCH;
                end
            end
            S_FETCH:  begin cmd.fetch = 1'b1; state_next = S_DECODE; end
            S_DECODE: begin cmd.decode = 1'b1; state_next = S_EXEC; end
            S_EXEC:
            begin
                cmd.execute = 1'b1;
                if (status.is_md)
                begin
                    cmd.md_start = 1'b1;
                    state_next = S_MDWAIT;
                end
                else if (status.is_load)
                    state_next = S_MEM;
                else
                    state_next = S_COMMIT;
            end
            S_MEM:    begin cmd.mem_rd = 1'b1; state_next = S_MD; end
            S_MD:     state_next = S_COMMIT;   // read data now registered
            S_MDWAIT: if (status.md_done) state_next = S_COMMIT;
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                ov_next    = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    assign out_valid = ov_reg;
endmodule

[rtl/mips_subset_core.sv]
// mips_subset_core: top level, stream ports around controller and datapath.
// Depends on msc_pkg, msc_ctrl, msc_datapath.
//
// channel   | direction | handshake            | content
// s_axis    | in        | tvalid/tready        | cmd, load_index, load_data
// m_axis    | out       | tvalid/tready        | one result per request
// cfg       | in        | cfg_valid/cfg_ready  | program_words
//
// Load and halted steps are answered from idle; others run fetch, decode,
// execute, commit; loads add S_MEM, S_MD; mul/div wait in S_MDWAIT.
// Reset clears pc, hi/lo, program_words and the register file;
// memory is undefined until loaded. A waiting result blocks new requests.
`timescale 1ns / 1ps
module mips_subset_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [41:0] = load_index[9:0], load_data[41:10]; zero pad to 48
    input  logic [47:0]  s_axis_tdata,
    // cmd
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // next_pc, reg_written, reg_index, reg_value, mem_written, mem_index,
    // mem_value, unknown_op, halted from bit 0 up; zero pad to 96
    output logic [95:0]  m_axis_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [10:0]  cfg_data
);
    import msc_pkg::*;

    cmd_t    cmd;
    status_t status;
    result_t res;
    logic    pc_done;
    logic [PW_W-1:0] pw_reg;

    // r0..r31 live in the datapath; program_words here
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pw_reg <= '0;
        else if (cfg_valid)
            pw_reg <= cfg_data;
    end
    assign cfg_ready = 1'b1;

    msc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_cmd    (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .pc_done   (pc_done),
        .status    (status),
        .cmd       (cmd),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready)
    );

    msc_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .load_index    (s_axis_tdata[9:0]),
        .load_data     (s_axis_tdata[41:10]),
        .program_words (pw_reg),
        .pc_done       (pc_done),
        .result        (res)
    );

    assign m_axis_tdata = {
        3'd0, res.halted, res.unknown_op, res.mem_value, res.mem_index,
        res.mem_written, res.reg_value, res.reg_index, res.reg_written, res.next_pc
    };
endmodule
